### sv/acds_pkg.sv
// shared types, codes and rate table for the audio clock divider search
package acds_pkg;

    localparam int FS_W     = 17;
    localparam int MCLK_W   = 26;
    localparam int DIV_W    = 29;
    localparam int ROW_W    = 4;
    localparam int SHIFT_W  = 3;

    localparam int                RECIP_W  = 32;
    localparam int                RECIP_SH = 33;
    localparam logic [RECIP_W-1:0] RECIP3  = 32'hAAAAAAAB;

    localparam int NUM_RATES = 9;
    localparam int NUM_N3    = 4;
    localparam int NUM_SHIFT = 5;

    localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(NUM_RATES - 1);
    localparam logic [1:0]         LAST_N3    = 2'(NUM_N3 - 1);
    localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(NUM_SHIFT - 1);

    localparam logic [1:0] N1_DIV1 = 2'd0;
    localparam logic [1:0] N1_DIV2 = 2'd1;
    localparam logic [1:0] N1_DIV3 = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_RATE    = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic [FS_W-1:0]   sample_rate;
        logic [MCLK_W-1:0] master_clock;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] rate_range;
        logic       div_max_flag;
        logic [1:0] n1_select;
        logic       mult_bypass;
        logic [1:0] mult_select;
        logic [2:0] n2_select;
        logic       clk4x_enable;
        logic       clk8x_enable;
    } t_out_item;

    typedef struct packed {
        logic [FS_W-1:0]        fs;
        logic [1:0]             range;
        logic                   maxf;
        logic [2:0][MCLK_W-1:0] clk;
    } t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DIRECT,
        S_TRIAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [ROW_W-1:0]   row_idx;
        logic [1:0]         n1;
        logic [1:0]         n3;
        logic [SHIFT_W-1:0] shift;
        logic               take;
        logic               direct;
        logic               load_out;
        logic [1:0]         status;
    } t_cmd;

    typedef struct packed {
        logic zero_in;
        logic row_hit;
        logic shift_hit;
        logic div_done;
        logic best_valid;
        logic out_full;
    } t_stat;

    function automatic t_row rate_row(input logic [ROW_W-1:0] idx);
        t_row r;
        r = '0;
        unique case (idx)
            4'd0: r = '{17'd48000, 2'd2, 1'b1, {26'd24000000, 26'd19200000, 26'd12288000}};
            4'd1: r = '{17'd16000, 2'd1, 1'b0, {26'd8000000, 26'd6400000, 26'd4096000}};
            4'd2: r = '{17'd8000, 2'd0, 1'b0, {26'd4000000, 26'd3200000, 26'd2048000}};
            4'd3: r = '{17'd44100, 2'd2, 1'b1, {26'd22050000, 26'd17640000, 26'd11289600}};
            4'd4: r = '{17'd64000, 2'd3, 1'b0, {26'd32000000, 26'd25600000, 26'd16384000}};
            4'd5: r = '{17'd96000, 2'd3, 1'b1, {26'd48000000, 26'd38400000, 26'd24576000}};
            4'd6: r = '{17'd12000, 2'd0, 1'b1, {26'd6000000, 26'd4800000, 26'd3072000}};
            4'd7: r = '{17'd24000, 2'd1, 1'b1, {26'd12000000, 26'd9600000, 26'd6144000}};
            4'd8: r = '{17'd32000, 2'd2, 1'b0, {26'd16000000, 26'd12800000, 26'd8192000}};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/audio_clock_divider_search.sv
// top level of the audio clock divider search
// An item is a sample rate and a master clock; one result item comes back with the chosen
// divider settings and a status. Items are taken one at a time: the block stalls its input
// from acceptance until the result is written to the output register, which can still hold
// the previous result while the next item is taken. The time from one acceptance to the
// next grows with R, the table position of the rate (1 to 9), and with S, the number of
// shift compares: up to 5 for the direct match and up to 5 for each of the twelve divider
// trials, 65 at most; a full output register that stays stalled holds the result back.
// Zero inputs and unsupported rates finish right after the lookup. The search loop checks
// one shift of one trial value per cycle, except while a divide-by-three trial waits for
// its quotient, which comes from a reciprocal multiplication whose operand and product are
// registered in turn after acceptance, long before those trials.
module audio_clock_divider_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  acds_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output acds_pkg::t_out_item  o_out_item
);
    import acds_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    acds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    acds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

### sv/acds_div3.sv
// divide by three of the master clock times eight by reciprocal multiplication
module acds_div3 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [acds_pkg::DIV_W-1:0]  i_dividend,
    output logic [acds_pkg::DIV_W-1:0]  o_quotient,
    output logic                        o_done
);
    import acds_pkg::*;

    logic [DIV_W-1:0]         r_x;
    logic [DIV_W-1:0]         r_q;
    logic                     r_load;
    logic                     r_busy;
    logic [DIV_W+RECIP_W-1:0] w_prod;

    assign w_prod = (DIV_W+RECIP_W)'(r_x) * (DIV_W+RECIP_W)'(RECIP3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            r_load <= i_start;
            r_busy <= i_start || r_load;
        end
        if (i_start) begin
            r_x <= i_dividend;
        end
        r_q <= DIV_W'(w_prod[DIV_W+RECIP_W-1:RECIP_SH]);
    end

    assign o_quotient = r_q;
    assign o_done     = !r_busy;

endmodule

### sv/acds_dp.sv
// datapath: input registers, trial value, clock compare, best match and result register
module acds_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  acds_pkg::t_in_item   i_in_item,
    input  acds_pkg::t_cmd       i_cmd,
    output acds_pkg::t_stat      o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output acds_pkg::t_out_item  o_out_item
);
    import acds_pkg::*;

    logic [FS_W-1:0]    r_fs;
    logic [MCLK_W-1:0]  r_mclk;
    logic               r_best_valid;
    logic [DIV_W-1:0]   r_best_m;
    logic [1:0]         r_best_n1;
    logic [1:0]         r_best_n3;
    logic [SHIFT_W-1:0] r_best_n2;
    logic               r_direct;
    t_out_item          r_out, n_out;
    logic               r_out_valid;

    t_row               w_row;
    logic [DIV_W-1:0]   w_q3;
    logic               w_div_done;
    logic [DIV_W-1:0]   w_mclk_sh;
    logic [DIV_W-1:0]   w_m;
    logic [DIV_W-1:0]   w_v;
    logic               w_hit;
    logic               w_better;

    acds_div3 u_div3 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend ({i_in_item.master_clock, 3'b000}),
        .o_quotient (w_q3),
        .o_done     (w_div_done)
    );

    always_comb begin
        w_row     = rate_row(i_cmd.row_idx);
        w_mclk_sh = DIV_W'(r_mclk) << i_cmd.n3;
        case (i_cmd.n1)
            N1_DIV1: w_m = w_mclk_sh;
            N1_DIV2: w_m = w_mclk_sh >> 1;
            default: w_m = w_q3 >> (LAST_N3 - i_cmd.n3);
        endcase
        w_v   = w_m >> i_cmd.shift;
        w_hit = (w_v == DIV_W'(w_row.clk[0])) || (w_v == DIV_W'(w_row.clk[1]))
             || (w_v == DIV_W'(w_row.clk[2]));
        w_better = !r_best_valid || (r_best_n1 < i_cmd.n1) || (w_m > r_best_m);
    end

    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.status;
        if (i_cmd.status == ST_OK) begin
            n_out.rate_range   = w_row.range;
            n_out.div_max_flag = w_row.maxf;
            n_out.n1_select    = r_best_n1;
            n_out.mult_bypass  = r_direct;
            n_out.mult_select  = r_best_n3;
            n_out.n2_select    = r_best_n2;
            n_out.clk4x_enable = r_best_n3[1];
            n_out.clk8x_enable = (r_best_n3 == LAST_N3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_best_valid <= 1'b0;
            end else if (i_cmd.take && w_better) begin
                r_best_valid <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.start) begin
            r_fs   <= i_in_item.sample_rate;
            r_mclk <= i_in_item.master_clock;
        end
        if (i_cmd.take && w_better) begin
            r_best_m  <= w_m;
            r_best_n1 <= i_cmd.n1;
            r_best_n3 <= i_cmd.n3;
            r_best_n2 <= i_cmd.shift;
            r_direct  <= i_cmd.direct;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_stat.zero_in    = (r_fs == '0) || (r_mclk == '0);
    assign o_stat.row_hit    = (r_fs == w_row.fs);
    assign o_stat.shift_hit  = w_hit;
    assign o_stat.div_done   = w_div_done;
    assign o_stat.best_valid = r_best_valid;
    assign o_stat.out_full   = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

endmodule

### sv/acds_ctrl.sv
// controller: sequences row lookup, direct match and divider trials
module acds_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  acds_pkg::t_stat  i_stat,
    output acds_pkg::t_cmd   o_cmd
);
    import acds_pkg::*;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [1:0]         r_n1, n_n1;
    logic [1:0]         r_n3, n_n3;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [1:0]         r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_n1    <= '0;
            r_n3    <= '0;
            r_shift <= '0;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_n1    <= n_n1;
            r_n3    <= n_n3;
            r_shift <= n_shift;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_row          = r_row;
        n_n1           = r_n1;
        n_n3           = r_n3;
        n_shift        = r_shift;
        n_code         = r_code;
        o_in_stall     = 1'b1;
        o_cmd          = '0;
        o_cmd.row_idx  = r_row;
        o_cmd.n1       = r_n1;
        o_cmd.n3       = r_n3;
        o_cmd.shift    = r_shift;
        o_cmd.status   = r_code;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_row       = '0;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_stat.zero_in) begin
                    n_code  = ST_ZERO;
                    n_state = S_DONE;
                end else if (i_stat.row_hit) begin
                    n_code  = ST_OK;
                    n_n1    = N1_DIV1;
                    n_n3    = '0;
                    n_shift = '0;
                    n_state = S_DIRECT;
                end else if (r_row == LAST_ROW) begin
                    n_code  = ST_RATE;
                    n_state = S_DONE;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_DIRECT: begin
                o_cmd.direct = 1'b1;
                if (i_stat.shift_hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DONE;
                end else if (r_shift == LAST_SHIFT) begin
                    n_shift = '0;
                    n_state = S_TRIAL;
                end else begin
                    n_shift = r_shift + SHIFT_W'(1);
                end
            end
            S_TRIAL: begin
                if (r_n1 != N1_DIV3 || i_stat.div_done) begin
                    o_cmd.take = i_stat.shift_hit;
                    if (i_stat.shift_hit || r_shift == LAST_SHIFT) begin
                        n_shift = '0;
                        if (r_n3 == LAST_N3) begin
                            n_n3 = '0;
                            if (r_n1 == N1_DIV3) begin
                                n_state = S_DONE;
                            end else begin
                                n_n1 = r_n1 + 2'd1;
                            end
                        end else begin
                            n_n3 = r_n3 + 2'd1;
                        end
                    end else begin
                        n_shift = r_shift + SHIFT_W'(1);
                    end
                end
            end
            S_DONE: begin
                o_cmd.status = (r_code == ST_OK && !i_stat.best_valid) ? ST_NOMATCH : r_code;
                if (!i_stat.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> (r_row <= LAST_ROW))
        else $error("row index beyond table");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIRECT || r_state == S_TRIAL) |-> (r_shift <= LAST_SHIFT))
        else $error("shift index out of range");

    a_n1_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIAL) |-> (r_n1 <= N1_DIV3))
        else $error("n1 index out of range");

    a_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIAL && r_n1 == N1_DIV3 && o_cmd.take) |-> i_stat.div_done)
        else $error("divide by three trial used before quotient ready");

    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_stat.out_full) |=> (r_state == S_IDLE))
        else $error("result not loaded when output register free");

endmodule
